[hw/rtl/ycc2rgb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ycc2rgb_pkg;

    // Field widths of the stream items.
    localparam int SAMPLE_W  = 8;
    localparam int IN_DATA_W = 6 * SAMPLE_W;
    localparam int PIXEL_W   = 3 * SAMPLE_W;
    localparam int OUT_DATA_W = 4 * PIXEL_W;

    // Offset-removed samples, products and scaled terms (all signed).
    localparam int OFFS_W = 10;
    localparam int PROD_W = 26;
    localparam int TERM_W = 10;
    localparam int SUM_W  = 11;

    // Sample offsets and the channel ceiling.
    localparam logic signed [OFFS_W-1:0] LUMA_OFFSET   = 10'sd16;
    localparam logic signed [OFFS_W-1:0] CHROMA_OFFSET = 10'sd128;
    localparam logic signed [SUM_W-1:0]  CHAN_MAX      = 11'sd255;

    // Fixed-point conversion coefficients.
    localparam logic signed [PROD_W-1:0] K_RED_CR   = 26'sd52298;
    localparam logic signed [PROD_W-1:0] K_GREEN_CR = 26'sd53281;
    localparam logic signed [PROD_W-1:0] K_GREEN_CB = 26'sd25625;
    localparam logic signed [PROD_W-1:0] K_BLUE_CB  = 26'sd33063;
    localparam logic signed [PROD_W-1:0] K_LUMA     = 26'sd38142;

    // Right shifts that go with each coefficient.
    localparam int SHIFT_RED   = 15;
    localparam int SHIFT_GREEN = 16;
    localparam int SHIFT_BLUE  = 14;
    localparam int SHIFT_LUMA  = 15;

    // Chroma terms shared by the four pixels of a group.
    typedef struct packed {
        logic signed [TERM_W-1:0] red;
        logic signed [TERM_W-1:0] green;
        logic signed [TERM_W-1:0] blue;
    } chroma_terms_t;

endpackage

`default_nettype wire

[hw/rtl/ycc2rgb_chroma.sv]
`timescale 1ns / 1ps
`default_nettype none

module ycc2rgb_chroma (
    input  wire logic [ycc2rgb_pkg::SAMPLE_W-1:0] chroma_blue,
    input  wire logic [ycc2rgb_pkg::SAMPLE_W-1:0] chroma_red,
    output ycc2rgb_pkg::chroma_terms_t            terms
);

    logic signed [ycc2rgb_pkg::OFFS_W-1:0] cb_s;
    logic signed [ycc2rgb_pkg::OFFS_W-1:0] cr_s;
    logic signed [ycc2rgb_pkg::PROD_W-1:0] prod_red;
    logic signed [ycc2rgb_pkg::PROD_W-1:0] prod_green;
    logic signed [ycc2rgb_pkg::PROD_W-1:0] prod_blue;

    // Remove the chroma offset; the results lie in -128..127.
    assign cb_s = signed'({2'b00, chroma_blue}) - ycc2rgb_pkg::CHROMA_OFFSET;
    assign cr_s = signed'({2'b00, chroma_red}) - ycc2rgb_pkg::CHROMA_OFFSET;

    // Constant-coefficient products; the green one needs both chroma samples.
    assign prod_red   = ycc2rgb_pkg::K_RED_CR * ycc2rgb_pkg::PROD_W'(cr_s);
    assign prod_green = -(ycc2rgb_pkg::K_GREEN_CR * ycc2rgb_pkg::PROD_W'(cr_s))
                        - ycc2rgb_pkg::K_GREEN_CB * ycc2rgb_pkg::PROD_W'(cb_s);
    assign prod_blue  = ycc2rgb_pkg::K_BLUE_CB * ycc2rgb_pkg::PROD_W'(cb_s);

    // Arithmetic shifts floor toward minus infinity; the terms fit in ten bits.
    assign terms.red   = ycc2rgb_pkg::TERM_W'(prod_red >>> ycc2rgb_pkg::SHIFT_RED);
    assign terms.green = ycc2rgb_pkg::TERM_W'(prod_green >>> ycc2rgb_pkg::SHIFT_GREEN);
    assign terms.blue  = ycc2rgb_pkg::TERM_W'(prod_blue >>> ycc2rgb_pkg::SHIFT_BLUE);

endmodule

`default_nettype wire

[hw/rtl/ycc2rgb_pixel.sv]
`timescale 1ns / 1ps
`default_nettype none

module ycc2rgb_pixel (
    input  wire logic [ycc2rgb_pkg::SAMPLE_W-1:0] luma,
    input  wire ycc2rgb_pkg::chroma_terms_t       terms,
    output logic [ycc2rgb_pkg::PIXEL_W-1:0]       pixel
);

    logic signed [ycc2rgb_pkg::OFFS_W-1:0] y_s;
    logic signed [ycc2rgb_pkg::PROD_W-1:0] prod_luma;
    logic signed [ycc2rgb_pkg::TERM_W-1:0] luma_term;
    logic signed [ycc2rgb_pkg::SUM_W-1:0]  sum_red;
    logic signed [ycc2rgb_pkg::SUM_W-1:0]  sum_green;
    logic signed [ycc2rgb_pkg::SUM_W-1:0]  sum_blue;

    // Saturate a channel sum to 0..255.
    function automatic logic [ycc2rgb_pkg::SAMPLE_W-1:0] clamp_channel(
        input logic signed [ycc2rgb_pkg::SUM_W-1:0] v
    );
        logic [ycc2rgb_pkg::SAMPLE_W-1:0] r;
        if (v < 0)
        begin
            r = '0;
        end
        else if (v > ycc2rgb_pkg::CHAN_MAX)
        begin
            r = '1;
        end
        else
        begin
            r = v[ycc2rgb_pkg::SAMPLE_W-1:0];
        end
        return r;
    endfunction

    // Scaled luma term for this pixel.
    assign y_s       = signed'({2'b00, luma}) - ycc2rgb_pkg::LUMA_OFFSET;
    assign prod_luma = ycc2rgb_pkg::K_LUMA * ycc2rgb_pkg::PROD_W'(y_s);
    assign luma_term = ycc2rgb_pkg::TERM_W'(prod_luma >>> ycc2rgb_pkg::SHIFT_LUMA);

    // Channel sums, widened by one bit so they cannot wrap.
    assign sum_red   = ycc2rgb_pkg::SUM_W'(luma_term) + ycc2rgb_pkg::SUM_W'(terms.red);
    assign sum_green = ycc2rgb_pkg::SUM_W'(luma_term) + ycc2rgb_pkg::SUM_W'(terms.green);
    assign sum_blue  = ycc2rgb_pkg::SUM_W'(luma_term) + ycc2rgb_pkg::SUM_W'(terms.blue);

    // Pack R low, then G, then B.
    assign pixel = {clamp_channel(sum_blue), clamp_channel(sum_green), clamp_channel(sum_red)};

endmodule

`default_nettype wire

[hw/rtl/ycbcr_to_rgb_four_pixel.sv]
`timescale 1ns / 1ps
`default_nettype none

// Converts one group of four BT.601 luma samples sharing one Cb/Cr pair into four
// packed RGB pixels (R in the low byte, then G, then B), saturated to 0..255.
// An item is accepted on the slave side, held in an input register, converted by
// one pass of constant multipliers, adders and clamps, and stored in the result
// register when that register can load, so one item per cycle is sustained
// whenever the output is taken.
// Back-pressure from m_tready reaches s_tready in the same cycle through the
// two-register pipeline's load enables.
// The end-of-image flag travels as tlast and comes out with its own group.
module ycbcr_to_rgb_four_pixel (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // luma0, chroma_blue, chroma_red, luma1, luma2, luma3 (8 bits each, from bit 0)
    input  wire logic [ycc2rgb_pkg::IN_DATA_W-1:0]   s_tdata,
    // end_of_image
    input  wire logic                                s_tlast,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // pixel0, pixel1, pixel2, pixel3 (24 bits each, from bit 0)
    output logic [ycc2rgb_pkg::OUT_DATA_W-1:0]       m_tdata,
    // last_group
    output logic                                     m_tlast
);

    localparam int SW = ycc2rgb_pkg::SAMPLE_W;
    localparam int PW = ycc2rgb_pkg::PIXEL_W;

    logic                                  in_valid_reg;
    logic [ycc2rgb_pkg::IN_DATA_W-1:0]     in_data_reg;
    logic                                  in_last_reg;
    logic                                  out_valid_reg;
    logic [ycc2rgb_pkg::OUT_DATA_W-1:0]    out_data_reg;
    logic                                  out_last_reg;
    logic                                  out_load;
    logic                                  in_load;
    logic                                  out_valid_next;
    logic                                  in_valid_next;
    logic [ycc2rgb_pkg::OUT_DATA_W-1:0]    out_data_next;
    ycc2rgb_pkg::chroma_terms_t            terms;

    // Each stage loads when it is empty or its content moves on this cycle.
    assign out_load = !out_valid_reg || m_tready;
    assign in_load  = !in_valid_reg || out_load;
    assign s_tready = in_load;

    assign in_valid_next  = in_load ? s_tvalid : in_valid_reg;
    assign out_valid_next = out_load ? in_valid_reg : out_valid_reg;

    // Stage valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input register.
    always_ff @(posedge clk)
    begin
        if (in_load && s_tvalid)
        begin
            in_data_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Chroma terms shared by the group.
    ycc2rgb_chroma u_chroma (
        .chroma_blue (in_data_reg[2*SW-1:SW]),
        .chroma_red  (in_data_reg[3*SW-1:2*SW]),
        .terms       (terms)
    );

    // Per-pixel luma term, sum and clamp.
    ycc2rgb_pixel u_pixel0 (
        .luma  (in_data_reg[SW-1:0]),
        .terms (terms),
        .pixel (out_data_next[PW-1:0])
    );

    ycc2rgb_pixel u_pixel1 (
        .luma  (in_data_reg[4*SW-1:3*SW]),
        .terms (terms),
        .pixel (out_data_next[2*PW-1:PW])
    );

    ycc2rgb_pixel u_pixel2 (
        .luma  (in_data_reg[5*SW-1:4*SW]),
        .terms (terms),
        .pixel (out_data_next[3*PW-1:2*PW])
    );

    ycc2rgb_pixel u_pixel3 (
        .luma  (in_data_reg[6*SW-1:5*SW]),
        .terms (terms),
        .pixel (out_data_next[4*PW-1:3*PW])
    );

    // Result register.
    always_ff @(posedge clk)
    begin
        if (out_load && in_valid_reg)
        begin
            out_data_reg <= out_data_next;
            out_last_reg <= in_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

[hw/rtl/ycc2rgb_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module ycc2rgb_checker (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    input  wire logic                              s_tready,
    input  wire logic                              m_tvalid,
    input  wire logic                              m_tready,
    input  wire logic [ycc2rgb_pkg::OUT_DATA_W-1:0] m_tdata,
    input  wire logic                              m_tlast
);

    // A stalled result keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // With the result register empty the block always takes an item.
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("not ready with empty output");

    // The input side stalls only behind a stalled result.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output back-pressure");

    // An accepted item reaches the output by way of the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> ##1 m_tvalid)
        else $error("accepted item did not reach the output");

endmodule

bind ycbcr_to_rgb_four_pixel ycc2rgb_checker u_ycc2rgb_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

[dv/ycbcr_to_rgb_four_pixel_tb.sv]
`timescale 1ns / 1ps

// Input samples laid out as on s_tdata: luma0 in the low byte, luma3 in the high byte.
typedef struct packed {
    logic [7:0] luma3;
    logic [7:0] luma2;
    logic [7:0] luma1;
    logic [7:0] chroma_red;
    logic [7:0] chroma_blue;
    logic [7:0] luma0;
} ycc_group_t;

// Four packed RGB pixels, pixel0 in the low bits as on m_tdata.
typedef logic [3:0][ycc2rgb_pkg::PIXEL_W-1:0] rgb_quad_t;

// Predicts the RGB pixels of each accepted group and checks the results in order.
class rgb_scoreboard;
    rgb_quad_t pending_pixels[$];
    logic      pending_last[$];
    int        errors;

    function new();
        errors = 0;
    endfunction

    // Clamp a channel sum to the 0..255 range of one byte.
    function logic [7:0] clamp_channel(longint sum);
        if (sum < 0)
            return 8'd0;
        if (sum > 255)
            return 8'd255;
        return sum[7:0];
    endfunction

    // Fixed-point BT.601 conversion; >>> on a signed longint rounds toward minus infinity.
    function rgb_quad_t convert_group(ycc_group_t g);
        longint    cb;
        longint    cr;
        longint    red_term;
        longint    green_term;
        longint    blue_term;
        longint    luma_term;
        logic [7:0] lumas [4];
        rgb_quad_t px;
        cb = longint'(g.chroma_blue) - longint'(ycc2rgb_pkg::CHROMA_OFFSET);
        cr = longint'(g.chroma_red) - longint'(ycc2rgb_pkg::CHROMA_OFFSET);
        red_term   = (longint'(ycc2rgb_pkg::K_RED_CR) * cr) >>> ycc2rgb_pkg::SHIFT_RED;
        green_term = (-longint'(ycc2rgb_pkg::K_GREEN_CR) * cr
                      - longint'(ycc2rgb_pkg::K_GREEN_CB) * cb) >>> ycc2rgb_pkg::SHIFT_GREEN;
        blue_term  = (longint'(ycc2rgb_pkg::K_BLUE_CB) * cb) >>> ycc2rgb_pkg::SHIFT_BLUE;
        lumas[0] = g.luma0;
        lumas[1] = g.luma1;
        lumas[2] = g.luma2;
        lumas[3] = g.luma3;
        for (int i = 0; i < 4; i++)
        begin
            luma_term = (longint'(ycc2rgb_pkg::K_LUMA)
                         * (longint'(lumas[i]) - longint'(ycc2rgb_pkg::LUMA_OFFSET)))
                        >>> ycc2rgb_pkg::SHIFT_LUMA;
            px[i] = {clamp_channel(luma_term + blue_term),
                     clamp_channel(luma_term + green_term),
                     clamp_channel(luma_term + red_term)};
        end
        return px;
    endfunction

    // An accepted input item queues its expected result.
    function void note_group(ycc_group_t g, logic end_of_image);
        pending_pixels.push_back(convert_group(g));
        pending_last.push_back(end_of_image);
    endfunction

    // Count and print one field mismatch.
    function void report(string field, longint unsigned expected, longint unsigned actual);
        errors++;
        $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
                 $time, field, expected, actual);
    endfunction

    // Compare an accepted result with the oldest expectation, field by field.
    function void check_result(rgb_quad_t px, logic last_group);
        rgb_quad_t exp_px;
        logic      exp_last;
        if (pending_pixels.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected result: expected none, actual 0x%0h last %0b",
                     $time, px, last_group);
            return;
        end
        exp_px   = pending_pixels.pop_front();
        exp_last = pending_last.pop_front();
        for (int i = 0; i < 4; i++)
        begin
            if (px[i] !== exp_px[i])
                report($sformatf("pixel%0d", i), exp_px[i], px[i]);
        end
        if (last_group !== exp_last)
            report("last_group", exp_last, last_group);
    endfunction

    function int pending();
        return pending_pixels.size();
    endfunction
endclass

module ycbcr_to_rgb_four_pixel_tb;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_GROUPS = 110;

    logic                                  clk      = 1'b0;
    logic                                  rst_n    = 1'b0;
    logic                                  s_tvalid = 1'b0;
    logic                                  s_tready;
    logic [ycc2rgb_pkg::IN_DATA_W-1:0]     s_tdata  = '0;
    logic                                  s_tlast  = 1'b0;
    logic                                  m_tvalid;
    logic                                  m_tready = 1'b0;
    logic [ycc2rgb_pkg::OUT_DATA_W-1:0]    m_tdata;
    logic                                  m_tlast;

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int cycle_count        = 0;

    rgb_scoreboard board = new();

    ycbcr_to_rgb_four_pixel dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #4 clk = ~clk;

    // Random back-pressure on the result side.
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Watch both handshakes; an input is noted before any result of the same edge is checked.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                board.note_group(ycc_group_t'(s_tdata), s_tlast);
            if (m_tvalid && m_tready)
                board.check_result(rgb_quad_t'(m_tdata), m_tlast);
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic ycc_group_t make_group(logic [7:0] y0, logic [7:0] cb, logic [7:0] cr,
                                              logic [7:0] y1, logic [7:0] y2, logic [7:0] y3);
        ycc_group_t g;
        g.luma0       = y0;
        g.chroma_blue = cb;
        g.chroma_red  = cr;
        g.luma1       = y1;
        g.luma2       = y2;
        g.luma3       = y3;
        return g;
    endfunction

    // Mostly uniform samples, with the range ends and offsets favored now and then.
    function automatic logic [7:0] pick_sample();
        if ($urandom_range(7) != 0)
            return 8'($urandom_range(255));
        case ($urandom_range(4))
            0: return 8'd0;
            1: return 8'd16;
            2: return 8'd128;
            3: return 8'd235;
            default: return 8'd255;
        endcase
    endfunction

    // Offer one group, idling first at the current rate, and wait for its acceptance.
    task automatic send_group(input ycc_group_t g, input logic end_of_image);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= g;
        s_tlast  <= end_of_image;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic send_random_groups(input int count);
        for (int i = 0; i < count; i++)
        begin
            send_group(make_group(pick_sample(), pick_sample(), pick_sample(),
                                  pick_sample(), pick_sample(), pick_sample()),
                       $urandom_range(7) == 0);
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed groups: range ends, clamping on both sides, chroma corners, end flag.
        send_group(make_group(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0), 1'b0);
        send_group(make_group(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255), 1'b1);
        send_group(make_group(8'd16, 8'd128, 8'd128, 8'd15, 8'd17, 8'd235), 1'b0);
        send_group(make_group(8'd235, 8'd128, 8'd128, 8'd236, 8'd254, 8'd128), 1'b0);
        send_group(make_group(8'd128, 8'd0, 8'd0, 8'd0, 8'd255, 8'd64), 1'b0);
        send_group(make_group(8'd128, 8'd255, 8'd255, 8'd0, 8'd255, 8'd64), 1'b0);
        send_group(make_group(8'd128, 8'd0, 8'd255, 8'd0, 8'd255, 8'd192), 1'b1);
        send_group(make_group(8'd128, 8'd255, 8'd0, 8'd0, 8'd255, 8'd192), 1'b0);
        send_group(make_group(8'd0, 8'd128, 8'd128, 8'd85, 8'd170, 8'd255), 1'b0);
        send_group(make_group(8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55), 1'b1);
        send_group(make_group(8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA), 1'b0);
        send_group(make_group(8'd16, 8'd127, 8'd129, 8'd16, 8'd16, 8'd16), 1'b0);
        send_group(make_group(8'd240, 8'd16, 8'd240, 8'd20, 8'd100, 8'd200), 1'b1);
        send_group(make_group(8'd60, 8'd240, 8'd16, 8'd20, 8'd100, 8'd200), 1'b0);

        // Random groups under each mix of source gaps and back-pressure.
        send_random_groups(RANDOM_GROUPS);
        sender_idle_pct    = 48;
        send_random_groups(RANDOM_GROUPS);
        sender_idle_pct    = 0;
        receiver_stall_pct = 48;
        send_random_groups(RANDOM_GROUPS);
        sender_idle_pct    = 34;
        receiver_stall_pct = 34;
        send_random_groups(RANDOM_GROUPS);
        s_tvalid <= 1'b0;

        // Drain the pipeline, then wait for any stray result.
        while (board.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (board.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
